/* hdl/spl_pkg.sv */
package spl_pkg;

	// Widths of the sample and result fields
	localparam int SAMPLE_W = 12;
	localparam int DEG_W = 9;
	localparam int DRIVE_W = 16;
	localparam int SAMPLE_MAX = 4095;

	// Shared multiplier operand width
	localparam int MUL_W = 32;

	// Drive division by the gain scale of 10000, done as an exact reciprocal multiply.
	// The accumulator is compared with the saturation point in the same step; the
	// reciprocal product is used only below that point, which lies under 2^30.
	localparam int DIV_IN_W = 30;
	localparam int DIV_SHIFT = 44;
	localparam logic [63:0] GAIN_SCALE = 64'd10000;
	localparam logic [63:0] DIV_RECIP = ((64'd1 << DIV_SHIFT) + GAIN_SCALE - 64'd1) / GAIN_SCALE;
	localparam logic [63:0] DRIVE_LIMIT = 64'd65536 * GAIN_SCALE;

	// Configuration register map
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam logic [2:0] REG_PROP_GAIN = 3'd0;
	localparam logic [2:0] REG_INTEGRAL_GAIN = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [2:0] REG_DEADBAND = 3'd3;
	localparam logic [2:0] REG_TARGET_LIMIT = 3'd4;

	localparam logic [15:0] RST_PROP_GAIN = 16'd20000;
	localparam logic [15:0] RST_INTEGRAL_GAIN = 16'd30;
	localparam logic [23:0] RST_DERIV_GAIN = 24'd8000000;
	localparam logic [8:0] RST_DEADBAND = 9'd10;
	localparam logic [8:0] RST_TARGET_LIMIT = 9'd264;

	typedef struct packed {
		logic [15:0] prop_gain;
		logic [15:0] integral_gain;
		logic [23:0] deriv_gain;
		logic [8:0] deadband;
		logic [8:0] target_limit;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] target_sample;
		logic [SAMPLE_W-1:0] position_sample;
	} sample_t;

	typedef struct packed {
		logic [DEG_W-1:0] position_deg;
		logic [DEG_W-1:0] target_deg;
		logic [DEG_W-1:0] abs_error;
		logic [DRIVE_W-1:0] drive;
		logic direction;
	} result_t;

	// Operand selection for the shared multiplier
	typedef enum logic [2:0] {
		MOP_NONE = 3'd0,
		MOP_TGT = 3'd1,
		MOP_POS = 3'd2,
		MOP_KI = 3'd3,
		MOP_KP = 3'd4,
		MOP_KD = 3'd5,
		MOP_DIV = 3'd6
	} mul_op_t;

	typedef struct packed {
		logic capture;
		mul_op_t mop;
		logic lat_tgt;
		logic lat_pos;
		logic acc_load;
		logic acc_add;
		logic lat_sat;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

endpackage

/* hdl/spl_regs.sv */
module spl_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [spl_pkg::PADDR_W-1:0] paddr,
	input logic [spl_pkg::PDATA_W-1:0] pwdata,
	output logic [spl_pkg::PDATA_W-1:0] prdata,
	output spl_pkg::cfg_t cfg
);
	import spl_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] reg_idx;

	assign reg_idx = paddr[4:2];
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain <= RST_PROP_GAIN;
			cfg_q.integral_gain <= RST_INTEGRAL_GAIN;
			cfg_q.deriv_gain <= RST_DERIV_GAIN;
			cfg_q.deadband <= RST_DEADBAND;
			cfg_q.target_limit <= RST_TARGET_LIMIT;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PROP_GAIN: cfg_q.prop_gain <= pwdata[15:0];
				REG_INTEGRAL_GAIN: cfg_q.integral_gain <= pwdata[15:0];
				REG_DERIV_GAIN: cfg_q.deriv_gain <= pwdata[23:0];
				REG_DEADBAND: cfg_q.deadband <= pwdata[8:0];
				REG_TARGET_LIMIT: cfg_q.target_limit <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	// Read-back mux
	always_comb begin
		case (reg_idx)
			REG_PROP_GAIN: prdata = PDATA_W'(cfg_q.prop_gain);
			REG_INTEGRAL_GAIN: prdata = PDATA_W'(cfg_q.integral_gain);
			REG_DERIV_GAIN: prdata = PDATA_W'(cfg_q.deriv_gain);
			REG_DEADBAND: prdata = PDATA_W'(cfg_q.deadband);
			REG_TARGET_LIMIT: prdata = PDATA_W'(cfg_q.target_limit);
			default: prdata = '0;
		endcase
	end

endmodule

/* hdl/spl_ctrl.sv */
module spl_ctrl (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_stall,
	input spl_pkg::dp_status_t status,
	output spl_pkg::dp_cmd_t cmd
);
	import spl_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_TGT = 9'b000000010,
		ST_POS = 9'b000000100,
		ST_KI = 9'b000001000,
		ST_KP = 9'b000010000,
		ST_KD = 9'b000100000,
		ST_ACC = 9'b001000000,
		ST_DIV = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign sample_stall = (state_q != ST_IDLE);

	// Sequencer: at most one multiply per step, result waits in DONE while the output is held
	always_comb begin
		cmd = '0;
		cmd.mop = MOP_NONE;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = sample_valid;
				if (sample_valid) state_nxt = ST_TGT;
			end
			ST_TGT: begin
				cmd.mop = MOP_TGT;
				state_nxt = ST_POS;
			end
			ST_POS: begin
				cmd.mop = MOP_POS;
				cmd.lat_tgt = 1'b1;
				state_nxt = ST_KI;
			end
			ST_KI: begin
				cmd.mop = MOP_KI;
				cmd.lat_pos = 1'b1;
				state_nxt = ST_KP;
			end
			ST_KP: begin
				cmd.mop = MOP_KP;
				cmd.acc_load = 1'b1;
				state_nxt = ST_KD;
			end
			ST_KD: begin
				cmd.mop = MOP_KD;
				cmd.acc_add = 1'b1;
				state_nxt = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_add = 1'b1;
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				cmd.mop = MOP_DIV;
				cmd.lat_sat = 1'b1;
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				cmd.finish = !status.out_busy;
				if (!status.out_busy) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* hdl/spl_dp.sv */
module spl_dp #(
	parameter int ADC_FULL_SCALE = 4095,
	parameter int FULL_SCALE_DEGREES = 270,
	parameter int SUM_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input spl_pkg::cfg_t cfg,
	input spl_pkg::sample_t sample,
	input spl_pkg::dp_cmd_t cmd,
	output spl_pkg::dp_status_t status,
	output logic result_valid,
	input logic result_stall,
	output spl_pkg::result_t result
);
	import spl_pkg::*;

	// Degree conversion floor(d*FSD/FS) as an exact reciprocal multiply:
	// with d < 2^DW and FS < 2^CW, a ceiling reciprocal over 2^(DW+CW) is exact.
	localparam int DMAX = (ADC_FULL_SCALE >= SAMPLE_MAX - ADC_FULL_SCALE) ?
		ADC_FULL_SCALE : SAMPLE_MAX - ADC_FULL_SCALE;
	localparam int DW = $clog2(DMAX + 1);
	localparam int CW = $clog2(ADC_FULL_SCALE + 1);
	localparam int DEG_SHIFT = DW + CW;
	localparam logic [63:0] DEG_RECIP =
		((64'(FULL_SCALE_DEGREES) << DEG_SHIFT) + 64'(ADC_FULL_SCALE) - 64'd1) /
		64'(ADC_FULL_SCALE);
	localparam logic [16:0] FS = 17'(ADC_FULL_SCALE);
	localparam logic [63:0] FSD = 64'(FULL_SCALE_DEGREES);
	// ki*sum is SUM_BITS+16 bits; three terms plus headroom
	localparam int ACC_W = SUM_BITS + 19;

	sample_t smp_q;
	logic [2*MUL_W-1:0] prod_q;
	logic [MUL_W-1:0] mul_a;
	logic [MUL_W-1:0] mul_b;
	logic [DEG_W-1:0] tgt_deg_q;
	logic [DEG_W-1:0] pos_deg_q;
	logic [DEG_W-1:0] err_q;
	logic [ACC_W-1:0] acc_q;
	logic sat_q;
	logic [DEG_W-1:0] prev_error_q;
	logic [DEG_W-1:0] prev_target_q;
	logic [SUM_BITS-1:0] error_sum_q;
	result_t result_q;
	logic result_valid_q;

	logic [63:0] deg_full;
	logic [DEG_W-1:0] deg;
	logic [DEG_W-1:0] tgt_clamped;
	logic [DEG_W-1:0] err_diff;
	logic deadband_hit;
	logic [SUM_BITS:0] sum_ext;
	logic [SUM_BITS-1:0] sum_sat;
	logic [DRIVE_W-1:0] drive;

	function automatic logic [DW-1:0] fs_dist(input logic [SAMPLE_W-1:0] v);
		logic [16:0] v_ext;
		v_ext = 17'(v);
		return (FS >= v_ext) ? DW'(FS - v_ext) : DW'(v_ext - FS);
	endfunction

	function automatic logic [DEG_W-1:0] abs_diff(input logic [DEG_W-1:0] a,
		input logic [DEG_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	assign status.out_busy = result_valid_q && result_stall;
	assign result_valid = result_valid_q;
	assign result = result_q;

	// Shared multiplier operand select
	always_comb begin
		case (cmd.mop)
			MOP_TGT: begin
				mul_a = MUL_W'(fs_dist(smp_q.target_sample));
				mul_b = DEG_RECIP[MUL_W-1:0];
			end
			MOP_POS: begin
				mul_a = MUL_W'(fs_dist(smp_q.position_sample));
				mul_b = DEG_RECIP[MUL_W-1:0];
			end
			MOP_KI: begin
				mul_a = MUL_W'(error_sum_q);
				mul_b = MUL_W'(cfg.integral_gain);
			end
			MOP_KP: begin
				mul_a = MUL_W'(err_q);
				mul_b = MUL_W'(cfg.prop_gain);
			end
			MOP_KD: begin
				mul_a = MUL_W'(abs_diff(err_q, prev_error_q));
				mul_b = MUL_W'(cfg.deriv_gain);
			end
			MOP_DIV: begin
				mul_a = MUL_W'(acc_q[DIV_IN_W-1:0]);
				mul_b = DIV_RECIP[MUL_W-1:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Angle from the product, saturated at full scale; target clamp and error difference
	always_comb begin
		deg_full = prod_q >> DEG_SHIFT;
		deg = (deg_full > FSD) ? DEG_W'(FULL_SCALE_DEGREES) : deg_full[DEG_W-1:0];
		tgt_clamped = (deg > cfg.target_limit) ? cfg.target_limit : deg;
		err_diff = abs_diff(tgt_deg_q, deg);
	end

	// Final result: deadband, saturating sum and drive
	always_comb begin
		deadband_hit = (err_q < cfg.deadband) && (prev_target_q == tgt_deg_q);
		sum_ext = (SUM_BITS + 1)'(error_sum_q) + (SUM_BITS + 1)'(err_q);
		sum_sat = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
		drive = sat_q ? '1 : prod_q[DIV_SHIFT +: DRIVE_W];
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) smp_q <= sample;
		if (cmd.mop != MOP_NONE) prod_q <= mul_a * mul_b;
		if (cmd.lat_tgt) tgt_deg_q <= tgt_clamped;
		if (cmd.lat_pos) begin
			pos_deg_q <= deg;
			err_q <= err_diff;
		end
		if (cmd.acc_load) acc_q <= ACC_W'(prod_q);
		else if (cmd.acc_add) acc_q <= acc_q + ACC_W'(prod_q);
		if (cmd.lat_sat) sat_q <= (64'(acc_q) >= DRIVE_LIMIT);
		if (cmd.finish) begin
			result_q.position_deg <= pos_deg_q;
			result_q.target_deg <= tgt_deg_q;
			result_q.abs_error <= deadband_hit ? '0 : err_q;
			result_q.drive <= deadband_hit ? '0 : drive;
			result_q.direction <= (tgt_deg_q <= pos_deg_q);
		end
	end

	// Loop state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			prev_target_q <= '0;
			error_sum_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				prev_error_q <= deadband_hit ? '0 : err_q;
				prev_target_q <= tgt_deg_q;
				error_sum_q <= deadband_hit ? '0 : sum_sat;
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hdl/servo_pid_position_loop.sv */
// Channel   Handshake                     Payload
// sample    sample_valid / sample_stall   sample (target_sample, position_sample)
// result    result_valid / result_stall   result (position_deg .. direction)
// config    psel / penable / pwrite       paddr, pwdata, prdata (pready tied high)
//
// An item's result becomes valid after six products through the
// single shared 32x32 multiplier, one accumulate step and one finish step.
// The next item is accepted in the cycle after the previous one has moved into the
// output register, so a new item is never taken while one is still in flight.
// A stalled result holds the sequencer in its last step until the result is taken.
// Reset clears the loop state (previous error, previous target, error sum) and
// loads the register defaults.
module servo_pid_position_loop #(
	parameter int ADC_FULL_SCALE = 4095,
	parameter int FULL_SCALE_DEGREES = 270,
	parameter int SUM_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [spl_pkg::PADDR_W-1:0] paddr,
	input logic [spl_pkg::PDATA_W-1:0] pwdata,
	output logic [spl_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	input logic sample_valid,
	output logic sample_stall,
	input spl_pkg::sample_t sample,
	output logic result_valid,
	input logic result_stall,
	output spl_pkg::result_t result
);
	import spl_pkg::*;

	cfg_t cfg;
	dp_cmd_t cmd;
	dp_status_t status;

	assign pready = 1'b1;

	spl_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.cfg(cfg)
	);

	spl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.status(status),
		.cmd(cmd)
	);

	spl_dp #(
		.ADC_FULL_SCALE(ADC_FULL_SCALE),
		.FULL_SCALE_DEGREES(FULL_SCALE_DEGREES),
		.SUM_BITS(SUM_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.sample(sample),
		.cmd(cmd),
		.status(status),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// An accepted item keeps the input side closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> sample_stall)
		else $error("input not held off after accepting an item");

	// A new result only appears at the end of an item's sequence
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_stall))
		else $error("result raised without an item in flight");

	// Direction agrees with the reported angles
	a_direction: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.direction == (result.target_deg <= result.position_deg)))
		else $error("direction inconsistent with angles");

	// Target clamp and position range
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.target_deg <= cfg.target_limit) &&
			(32'(result.position_deg) <= 32'(FULL_SCALE_DEGREES)))
		else $error("reported angle out of range");

endmodule

/* test/tb.sv */
module tb;
	import spl_pkg::*;

	localparam int ADC_FS = SAMPLE_MAX;
	localparam int DEG_FS = 270;
	localparam int ERR_SUM_W = 24;
	localparam logic [63:0] GAIN_DIVISOR = 64'd10000;
	localparam logic [63:0] DRIVE_CAP = 64'd65535;
	localparam logic [63:0] ERR_SUM_CAP = (64'd1 << ERR_SUM_W) - 64'd1;
	localparam int REG_SPAN = 4;
	// unmapped register slots, writes there must be dropped
	localparam int REG_HOLE_LO = 5;
	localparam int REG_HOLE_HI = 7;
	localparam int SETTLE_CYCLES = 20;
	// full-error steps that keep the error sum climbing
	localparam int BURST_ITEMS = 150;
	localparam int RANDOM_ITEMS = 160;

	// Loop predictor and pending-result store
	class loop_checker;
		cfg_t regs;
		logic [DEG_W-1:0] last_error;
		logic [DEG_W-1:0] last_target;
		logic [63:0] err_total;
		result_t pending_results[$];
		int unsigned fails;

		function new();
			regs.prop_gain = RST_PROP_GAIN;
			regs.integral_gain = RST_INTEGRAL_GAIN;
			regs.deriv_gain = RST_DERIV_GAIN;
			regs.deadband = RST_DEADBAND;
			regs.target_limit = RST_TARGET_LIMIT;
			last_error = '0;
			last_target = '0;
			err_total = '0;
			fails = 0;
		endfunction

		function void apply_reg(int unsigned idx, logic [PDATA_W-1:0] val);
			case (idx)
				REG_PROP_GAIN: regs.prop_gain = val[15:0];
				REG_INTEGRAL_GAIN: regs.integral_gain = val[15:0];
				REG_DERIV_GAIN: regs.deriv_gain = val[23:0];
				REG_DEADBAND: regs.deadband = val[8:0];
				REG_TARGET_LIMIT: regs.target_limit = val[8:0];
				default: ;
			endcase
		endfunction

		// ADC count to whole degrees; full scale reads as zero degrees
		function logic [63:0] to_degrees(logic [SAMPLE_W-1:0] v);
			logic [63:0] deg;
			deg = (64'(ADC_FS) - 64'(v)) * 64'(DEG_FS) / 64'(ADC_FS);
			if (deg > 64'(DEG_FS))
				deg = 64'(DEG_FS);
			return deg;
		endfunction

		function void note_sample(sample_t s);
			logic [63:0] tgt, pos, err, swing, acc, drv;
			result_t want;
			tgt = to_degrees(s.target_sample);
			pos = to_degrees(s.position_sample);
			if (tgt > 64'(regs.target_limit))
				tgt = 64'(regs.target_limit);
			err = (tgt >= pos) ? tgt - pos : pos - tgt;
			swing = (err >= 64'(last_error)) ? err - 64'(last_error) : 64'(last_error) - err;
			// sum term uses the error total from before this step
			acc = 64'(regs.prop_gain) * err + 64'(regs.integral_gain) * err_total
				+ 64'(regs.deriv_gain) * swing;
			drv = acc / GAIN_DIVISOR;
			if (drv > DRIVE_CAP)
				drv = DRIVE_CAP;
			// steady target with small error: drive, error and sum all cleared
			if (err < 64'(regs.deadband) && last_target == tgt[DEG_W-1:0]) begin
				drv = '0;
				err = '0;
				err_total = '0;
			end
			last_error = err[DEG_W-1:0];
			last_target = tgt[DEG_W-1:0];
			err_total = err_total + err;
			if (err_total > ERR_SUM_CAP)
				err_total = ERR_SUM_CAP;
			want.position_deg = pos[DEG_W-1:0];
			want.target_deg = tgt[DEG_W-1:0];
			want.abs_error = err[DEG_W-1:0];
			want.drive = drv[DRIVE_W-1:0];
			want.direction = (tgt <= pos);
			pending_results.push_back(want);
		endfunction

		function string show(result_t r);
			return $sformatf("pos=%0d tgt=%0d err=%0d drive=%0d dir=%0b",
				r.position_deg, r.target_deg, r.abs_error, r.drive, r.direction);
		endfunction

		function void flag(string msg);
			fails++;
			if (fails <= 10)
				$display("t=%0t mismatch: %s", $time, msg);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				flag({"result with nothing pending: ", show(got)});
				return;
			end
			want = pending_results.pop_front();
			if (got.position_deg !== want.position_deg || got.target_deg !== want.target_deg
				|| got.abs_error !== want.abs_error || got.drive !== want.drive
				|| got.direction !== want.direction)
				flag({"expected ", show(want), " got ", show(got)});
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic pready;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic sample_valid;
	logic sample_stall;
	sample_t sample;
	logic result_valid;
	logic result_stall;
	result_t result;
	// no idling on either side while set
	bit calm;
	loop_checker tracker = new();

	servo_pid_position_loop dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// Result side: random stall, check every accepted item
	initial begin
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall)
				tracker.check_result(result);
			result_stall <= !calm && ($urandom_range(99) < 30);
		end
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] tgt, input logic [SAMPLE_W-1:0] pos);
		sample_t s;
		s.target_sample = tgt;
		s.position_sample = pos;
		if (!calm && $urandom_range(99) < 30) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 40);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
		tracker.note_sample(s);
	endtask

	// Stop sending and let the block go idle
	task automatic drain_results();
		sample_valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup then access phase; bus left selected for a back-to-back write
	task automatic write_reg(input int unsigned idx, input logic [PDATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(idx * REG_SPAN);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.apply_reg(idx, val);
	endtask

	task automatic program_regs(input logic [PDATA_W-1:0] kp, input logic [PDATA_W-1:0] ki,
		input logic [PDATA_W-1:0] kd, input logic [PDATA_W-1:0] band,
		input logic [PDATA_W-1:0] limit);
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_INTEGRAL_GAIN, ki);
		write_reg(REG_DERIV_GAIN, kd);
		write_reg(REG_DEADBAND, band);
		write_reg(REG_TARGET_LIMIT, limit);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Mostly a held target with the position hovering near it, plus noise, extremes and repeated items
	task automatic random_phase(input int unsigned count);
		logic [SAMPLE_W-1:0] hold_tgt, tgt, pos;
		int near;
		hold_tgt = SAMPLE_W'($urandom);
		tgt = hold_tgt;
		pos = hold_tgt;
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(11) == 0)
				hold_tgt = SAMPLE_W'($urandom);
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					near = int'(hold_tgt) + int'($urandom_range(300)) - 150;
					if (near < 0)
						near = 0;
					if (near > ADC_FS)
						near = ADC_FS;
					tgt = hold_tgt;
					pos = SAMPLE_W'(near);
				end
				6, 7: begin
					tgt = SAMPLE_W'($urandom);
					pos = SAMPLE_W'($urandom);
				end
				8: begin
					tgt = $urandom_range(1) ? '1 : '0;
					pos = $urandom_range(1) ? '1 : '0;
				end
				// same item again
				default: ;
			endcase
			send_sample(tgt, pos);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sample_valid <= 1'b0;
		sample <= '0;
		calm = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults: target clamp, deadband entry, zero and full-scale angles
		send_sample(12'd0, 12'd0);
		send_sample(12'd0, 12'd0);
		send_sample(12'd4095, 12'd4095);
		send_sample(12'd4095, 12'd4095);
		send_sample(12'd4095, 12'd0);
		send_sample(12'd0, 12'd4095);
		send_sample(12'd2048, 12'd2048);
		send_sample(12'd2048, 12'd2100);
		send_sample(12'd2048, 12'd1000);
		send_sample(12'hAAA, 12'h555);
		send_sample(12'h555, 12'hAAA);

		// Unmapped writes dropped, oversized values masked, drive saturates
		drain_results();
		write_reg(REG_HOLE_LO, 32'h0000_0000);
		write_reg(REG_HOLE_HI, 32'hFFFF_FFFF);
		program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FE00, 32'hFFFF_FF0E);
		send_sample(12'd0, 12'd4095);
		send_sample(12'd4095, 12'd0);
		send_sample(12'd100, 12'd3000);
		send_sample(12'd100, 12'd3000);

		// Zero target limit, widest deadband
		drain_results();
		program_regs(32'd0, 32'd0, 32'd0, 32'd511, 32'd0);
		send_sample(12'd0, 12'd0);
		send_sample(12'd0, 12'd0);
		send_sample(12'd4095, 12'd2000);

		// Full error every step, integral term only, the error sum keeps growing
		drain_results();
		program_regs(32'd0, 32'd1, 32'd0, 32'd0, 32'd270);
		calm = 1'b1;
		for (int i = 0; i < BURST_ITEMS; i++)
			send_sample('1, '0);
		calm = 1'b0;

		drain_results();
		program_regs($urandom_range(40000), $urandom_range(100), $urandom_range(9000000),
			$urandom_range(30), $urandom_range(270, 150));
		random_phase(RANDOM_ITEMS);

		// Largest gains, no idling on either side
		drain_results();
		program_regs(32'd65535, 32'd65535, 32'hFF_FFFF, 32'd270, 32'd270);
		calm = 1'b1;
		random_phase(RANDOM_ITEMS);
		calm = 1'b0;

		// Raw random register words; sender holds off mid-phase until all results are in
		drain_results();
		program_regs($urandom, $urandom, $urandom, $urandom, $urandom);
		random_phase(RANDOM_ITEMS / 2);
		drain_results();
		random_phase(RANDOM_ITEMS / 2);

		drain_results();
		program_regs($urandom_range(65535), $urandom_range(200), $urandom_range(2000000),
			$urandom_range(270, 100), $urandom_range(270));
		random_phase(RANDOM_ITEMS);

		drain_results();
		if (tracker.fails == 0 && tracker.pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
